@@ rtl/shadow_silhouette_edge_finder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the silhouette edge finder
// Concurrent checks clocked by clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SHADOW_SILHOUETTE_EDGE_FINDER_MACROS_SVH
`define SHADOW_SILHOUETTE_EDGE_FINDER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SSEF_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define SSEF_NEVER(label, cond, msg) \
   `SSEF_CHECK(label, !(cond), msg)

`endif

@@ rtl/ssef_pkg.sv @@
// ----------------------------------------------------------------------------
// ssef_pkg
// Shared types and constants of the silhouette edge finder.
// ----------------------------------------------------------------------------
package ssef_pkg;

   // Fixed field widths of the request and response channels.
   localparam int FIX_BITS       = 32;
   localparam int VERT_BITS      = 16;
   localparam int SLOT_BITS      = 10;
   localparam int COUNT_OUT_BITS = 11;
   localparam int CSR_INDEX_BITS = 8;

   // Dot product datapath widths.
   localparam int VEC_BITS  = FIX_BITS + 1;
   localparam int PART_BITS = 17;
   localparam int PROD_BITS = FIX_BITS + PART_BITS;
   localparam int ACC_BITS  = 68;

   // Request opcodes.
   localparam logic [1:0] OP_CLEAR    = 2'd0;
   localparam logic [1:0] OP_TRIANGLE = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIRECTIONAL = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIGHT_X     = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIGHT_Y     = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIGHT_Z     = 8'd3;

   // Edge of the triangle being toggled.
   localparam logic [1:0] EDGE_AB = 2'd0;
   localparam logic [1:0] EDGE_BC = 2'd1;
   localparam logic [1:0] EDGE_CA = 2'd2;

   typedef struct packed {
      logic                       directional;
      logic signed [FIX_BITS-1:0] x;
      logic signed [FIX_BITS-1:0] y;
      logic signed [FIX_BITS-1:0] z;
   } ssef_light_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOT,
      ST_SCAN,
      ST_FETCH,
      ST_MOVE,
      ST_READ,
      ST_DONE
   } ssef_state_type;

endpackage

@@ rtl/ssef_edge_ram.sv @@
// ----------------------------------------------------------------------------
// ssef_edge_ram
// Edge table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssef_edge_ram #(
   parameter int DEPTH      = 1024,
   parameter int ADDR_BITS  = 10,
   parameter int DATA_BITS  = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ssef_dot_unit.sv @@
// ----------------------------------------------------------------------------
// ssef_dot_unit
// Exact sign of dot(normal, light vector), one 32x17 product per cycle.
// ----------------------------------------------------------------------------
module ssef_dot_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  ssef_pkg::ssef_light_type            light,
   input  logic signed [ssef_pkg::FIX_BITS-1:0] normal_x,
   input  logic signed [ssef_pkg::FIX_BITS-1:0] normal_y,
   input  logic signed [ssef_pkg::FIX_BITS-1:0] normal_z,
   input  logic signed [ssef_pkg::FIX_BITS-1:0] center_x,
   input  logic signed [ssef_pkg::FIX_BITS-1:0] center_y,
   input  logic signed [ssef_pkg::FIX_BITS-1:0] center_z,
   output logic                                done,
   output logic                                nonneg
);

   import ssef_pkg::*;

   localparam logic [2:0] LAST_STEP = 3'd5;

   logic signed [FIX_BITS-1:0]  n_ff [3];
   logic signed [FIX_BITS-1:0]  n_in [3];
   logic signed [VEC_BITS-1:0]  v_ff [3];
   logic signed [VEC_BITS-1:0]  v_in [3];
   logic                        busy_ff, busy_in;
   logic [2:0]                  step_ff, step_in;
   logic                        prod_vld_ff, prod_vld_in;
   logic                        prod_shift_ff, prod_shift_in;
   logic                        prod_last_ff, prod_last_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic                        done_ff, done_in;
   logic signed [FIX_BITS-1:0]  mul_a;
   logic signed [VEC_BITS-1:0]  vec_sel;
   logic signed [PART_BITS-1:0] mul_b;
   logic signed [ACC_BITS-1:0]  term;

   // Operand vector: light direction, or center minus light position.
   always_comb begin
      if (light.directional) begin
         v_in[0] = {light.x[FIX_BITS-1], light.x};
         v_in[1] = {light.y[FIX_BITS-1], light.y};
         v_in[2] = {light.z[FIX_BITS-1], light.z};
      end else begin
         v_in[0] = {center_x[FIX_BITS-1], center_x} - {light.x[FIX_BITS-1], light.x};
         v_in[1] = {center_y[FIX_BITS-1], center_y} - {light.y[FIX_BITS-1], light.y};
         v_in[2] = {center_z[FIX_BITS-1], center_z} - {light.z[FIX_BITS-1], light.z};
      end
      n_in[0] = normal_x;
      n_in[1] = normal_y;
      n_in[2] = normal_z;
   end

   // Each component is split into a signed upper part and an unsigned
   // lower sixteen bits; the upper product is weighted by 2^16.
   always_comb begin
      case (step_ff[2:1])
         2'd0: begin
            mul_a   = n_ff[0];
            vec_sel = v_ff[0];
         end
         2'd1: begin
            mul_a   = n_ff[1];
            vec_sel = v_ff[1];
         end
         default: begin
            mul_a   = n_ff[2];
            vec_sel = v_ff[2];
         end
      endcase
      if (step_ff[0]) begin
         mul_b = vec_sel[VEC_BITS-1:16];
      end else begin
         mul_b = {1'b0, vec_sel[15:0]};
      end
      if (prod_shift_ff) begin
         term = {{3{prod_ff[PROD_BITS-1]}}, prod_ff, 16'b0};
      end else begin
         term = {{19{prod_ff[PROD_BITS-1]}}, prod_ff};
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      step_in       = step_ff;
      prod_vld_in   = 1'b0;
      prod_shift_in = step_ff[0];
      prod_last_in  = (step_ff == LAST_STEP);
      prod_in       = mul_a * mul_b;
      acc_in        = acc_ff;
      done_in       = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         acc_in  = '0;
      end else begin
         if (busy_ff) begin
            prod_vld_in = 1'b1;
            step_in     = step_ff + 3'd1;
            if (step_ff == LAST_STEP) begin
               busy_in = 1'b0;
            end
         end
         if (prod_vld_ff) begin
            acc_in  = acc_ff + term;
            done_in = prod_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         prod_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         prod_vld_ff <= prod_vld_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff <= n_in;
         v_ff <= v_in;
      end
      step_ff       <= step_in;
      prod_shift_ff <= prod_shift_in;
      prod_last_ff  <= prod_last_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
   end

   assign done   = done_ff;
   assign nonneg = ~acc_ff[ACC_BITS-1];

endmodule

@@ rtl/shadow_silhouette_edge_finder.sv @@
// ----------------------------------------------------------------------------
// shadow_silhouette_edge_finder
// Silhouette edge table for shadow volumes, kept in one on-chip memory.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the req_ channel (valid/ready) and each one
// produces exactly one response on the rsp_ channel. A triangle request
// computes the exact sign of dot(normal, L) and, when it faces the light,
// toggles its edges AB, BC and CA in the edge table. A clear request empties
// the table and a read request returns one stored edge. The light is set
// through the csr_ write channel, which is always ready; write it only while
// no request is in flight.
// Timing. Clear and unused opcodes go straight to the response state, a read
// passes through the read state first, and a triangle waits for the dot
// unit. A facing triangle then scans the stored edges for each of its
// edges AB, BC and CA, one entry read per cycle, until it finds the edge;
// a found edge is removed by fetching the last entry and moving it into the
// matched slot, and a missing one is appended. This scan of the table memory
// sets the time of a facing triangle. One request is handled at a time.
// Reset. A synchronous reset empties the table (count zero), selects a
// directional light at the origin, and drops any pending response. The
// table memory itself is not cleared; only entries below the count are read.
// Stalls. A finished response waits in the output register until rsp_ready;
// the next request is not taken until that response has been loaded.
// ----------------------------------------------------------------------------
`include "shadow_silhouette_edge_finder_macros.svh"

module shadow_silhouette_edge_finder #(
   parameter int EDGE_CAPACITY = 1024,
   parameter int INDEX_BITS    = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // Request channel
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [1:0]                                req_opcode,
   input  logic [ssef_pkg::VERT_BITS-1:0]            req_vert_a,
   input  logic [ssef_pkg::VERT_BITS-1:0]            req_vert_b,
   input  logic [ssef_pkg::VERT_BITS-1:0]            req_vert_c,
   input  logic signed [ssef_pkg::FIX_BITS-1:0]      req_normal_x,
   input  logic signed [ssef_pkg::FIX_BITS-1:0]      req_normal_y,
   input  logic signed [ssef_pkg::FIX_BITS-1:0]      req_normal_z,
   input  logic signed [ssef_pkg::FIX_BITS-1:0]      req_center_x,
   input  logic signed [ssef_pkg::FIX_BITS-1:0]      req_center_y,
   input  logic signed [ssef_pkg::FIX_BITS-1:0]      req_center_z,
   input  logic [ssef_pkg::SLOT_BITS-1:0]            req_slot,
   // Response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_facing,
   output logic [ssef_pkg::COUNT_OUT_BITS-1:0]       rsp_edge_count,
   output logic [ssef_pkg::VERT_BITS-1:0]            rsp_read_first,
   output logic [ssef_pkg::VERT_BITS-1:0]            rsp_read_second,
   output logic                                      rsp_read_valid,
   output logic                                      rsp_overflow,
   // Configuration write channel
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [ssef_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [ssef_pkg::FIX_BITS-1:0]             csr_wdata
);

   import ssef_pkg::*;

   localparam int CNT_BITS  = $clog2(EDGE_CAPACITY + 1);
   localparam int ADDR_BITS = $clog2(EDGE_CAPACITY);
   localparam int WORD_BITS = 2 * INDEX_BITS;
   localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(EDGE_CAPACITY);
   localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

   // Sequencer state and table bookkeeping.
   ssef_state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]         total_ff, total_in;
   logic [CNT_BITS-1:0]         ptr_ff, ptr_in;
   logic                        pend_ff, pend_in;
   logic [ADDR_BITS-1:0]        pend_addr_ff, pend_addr_in;
   logic [ADDR_BITS-1:0]        match_ff, match_in;
   logic [1:0]                  edge_sel_ff, edge_sel_in;

   // Captured request fields and per-request flags.
   logic [INDEX_BITS-1:0]       vert_a_ff, vert_a_in;
   logic [INDEX_BITS-1:0]       vert_b_ff, vert_b_in;
   logic [INDEX_BITS-1:0]       vert_c_ff, vert_c_in;
   logic [SLOT_BITS-1:0]        slot_ff, slot_in;
   logic                        facing_ff, facing_in;
   logic                        ovf_ff, ovf_in;
   logic                        rd_ok_ff, rd_ok_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_facing_ff, rsp_facing_in;
   logic [COUNT_OUT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   logic [VERT_BITS-1:0]        rsp_first_ff, rsp_first_in;
   logic [VERT_BITS-1:0]        rsp_second_ff, rsp_second_in;
   logic                        rsp_rvalid_ff, rsp_rvalid_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   // Light configuration registers.
   ssef_light_type              light_ff, light_in;

   // Memory and dot unit connections.
   logic                        ram_we;
   logic [ADDR_BITS-1:0]        ram_waddr;
   logic [WORD_BITS-1:0]        ram_wdata;
   logic                        ram_re;
   logic [ADDR_BITS-1:0]        ram_raddr;
   logic [WORD_BITS-1:0]        ram_rdata;
   logic                        dot_start;
   logic                        dot_done;
   logic                        dot_nonneg;

   // Helper terms.
   logic                        req_fire;
   logic                        csr_fire;
   logic                        rsp_free;
   logic [INDEX_BITS-1:0]       edge_p, edge_q;
   logic [INDEX_BITS-1:0]       rd_first, rd_second;
   logic                        hit;
   logic                        scan_more;
   logic                        not_full;
   logic                        last_edge;
   logic                        slot_hit;
   logic [CNT_BITS-1:0]         last_idx;
   logic [INDEX_BITS+VERT_BITS-1:0] ext_a, ext_b, ext_c;
   logic [INDEX_BITS+VERT_BITS-1:0] ext_first, ext_second;
   logic [ADDR_BITS+SLOT_BITS-1:0]  ext_slot;
   logic [CNT_BITS+COUNT_OUT_BITS-1:0] ext_count;

   assign req_fire  = req_valid & req_ready;
   assign csr_fire  = csr_valid & csr_ready;
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // Width adaptation between the fixed ports and the parameterized table.
   assign ext_a      = {INDEX_BITS'(0), req_vert_a};
   assign ext_b      = {INDEX_BITS'(0), req_vert_b};
   assign ext_c      = {INDEX_BITS'(0), req_vert_c};
   assign ext_first  = {VERT_BITS'(0), rd_first};
   assign ext_second = {VERT_BITS'(0), rd_second};
   assign ext_slot   = {ADDR_BITS'(0), slot_ff};
   assign ext_count  = {COUNT_OUT_BITS'(0), total_ff};

   assign rd_first  = ram_rdata[WORD_BITS-1:INDEX_BITS];
   assign rd_second = ram_rdata[INDEX_BITS-1:0];
   assign last_idx  = total_ff - CNT_ONE;

   // The edges AB, BC and CA of a triangle, in toggle order.
   always_comb begin
      case (edge_sel_ff)
         EDGE_AB: begin
            edge_p = vert_a_ff;
            edge_q = vert_b_ff;
         end
         EDGE_BC: begin
            edge_p = vert_b_ff;
            edge_q = vert_c_ff;
         end
         default: begin
            edge_p = vert_c_ff;
            edge_q = vert_a_ff;
         end
      endcase
   end

   // The scan is pipelined: the word read for the previous pointer is compared
   // while the next one is being read. A match in either direction counts.
   assign hit = pend_ff &&
                ((rd_first == edge_p && rd_second == edge_q) ||
                 (rd_first == edge_q && rd_second == edge_p));
   assign scan_more = (ptr_ff < total_ff);
   assign not_full  = (total_ff < CAP_CNT);
   assign last_edge = (edge_sel_ff == EDGE_CA);
   assign slot_hit  = (32'(slot_ff) < 32'(total_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_opcode)
                  OP_TRIANGLE: state_in = ST_DOT;
                  OP_READ:     state_in = ST_READ;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_DOT: begin
            if (dot_done) begin
               state_in = dot_nonneg ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_FETCH;
            end else if (!scan_more && last_edge) begin
               state_in = ST_DONE;
            end
         end
         ST_FETCH: state_in = ST_MOVE;
         ST_MOVE:  state_in = last_edge ? ST_DONE : ST_SCAN;
         ST_READ:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Memory and dot unit control. Reads and writes never share a cycle, and
   // every write lands before the next scan read, so no forwarding is needed.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = total_ff[ADDR_BITS-1:0];
      ram_wdata = {edge_p, edge_q};
      ram_re    = 1'b0;
      ram_raddr = ptr_ff[ADDR_BITS-1:0];
      dot_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            dot_start = req_fire && (req_opcode == OP_TRIANGLE);
         end
         ST_SCAN: begin
            if (!hit) begin
               if (scan_more) begin
                  ram_re = 1'b1;
               end else begin
                  ram_we = not_full;
               end
            end
         end
         ST_FETCH: begin
            ram_re    = 1'b1;
            ram_raddr = last_idx[ADDR_BITS-1:0];
         end
         ST_MOVE: begin
            ram_we    = 1'b1;
            ram_waddr = match_ff;
            ram_wdata = ram_rdata;
         end
         ST_READ: begin
            ram_re    = slot_hit;
            ram_raddr = ext_slot[ADDR_BITS-1:0];
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      total_in      = total_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      match_in      = match_ff;
      edge_sel_in   = edge_sel_ff;
      vert_a_in     = vert_a_ff;
      vert_b_in     = vert_b_ff;
      vert_c_in     = vert_c_ff;
      slot_in       = slot_ff;
      facing_in     = facing_ff;
      ovf_in        = ovf_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_facing_in = rsp_facing_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               vert_a_in = ext_a[INDEX_BITS-1:0];
               vert_b_in = ext_b[INDEX_BITS-1:0];
               vert_c_in = ext_c[INDEX_BITS-1:0];
               slot_in   = req_slot;
               facing_in = 1'b0;
               ovf_in    = 1'b0;
               rd_ok_in  = 1'b0;
               if (req_opcode == OP_CLEAR) begin
                  total_in = '0;
               end
            end
         end
         ST_DOT: begin
            if (dot_done && dot_nonneg) begin
               facing_in   = 1'b1;
               edge_sel_in = EDGE_AB;
               ptr_in      = '0;
               pend_in     = 1'b0;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               match_in = pend_addr_ff;
            end else if (scan_more) begin
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff[ADDR_BITS-1:0];
               ptr_in       = ptr_ff + CNT_ONE;
            end else begin
               // Edge not present: append it, or flag a full table.
               if (not_full) begin
                  total_in = total_ff + CNT_ONE;
               end else begin
                  ovf_in = 1'b1;
               end
               edge_sel_in = edge_sel_ff + 2'd1;
               ptr_in      = '0;
               pend_in     = 1'b0;
            end
         end
         ST_MOVE: begin
            // The last entry has moved into the matched slot.
            total_in    = last_idx;
            edge_sel_in = edge_sel_ff + 2'd1;
            ptr_in      = '0;
            pend_in     = 1'b0;
         end
         ST_READ: begin
            rd_ok_in = slot_hit;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_facing_in = facing_ff;
               rsp_count_in  = ext_count[COUNT_OUT_BITS-1:0];
               rsp_rvalid_in = rd_ok_ff;
               rsp_ovf_in    = ovf_ff;
               if (rd_ok_ff) begin
                  rsp_first_in  = ext_first[VERT_BITS-1:0];
                  rsp_second_in = ext_second[VERT_BITS-1:0];
               end else begin
                  rsp_first_in  = '0;
                  rsp_second_in = '0;
               end
            end
         end
         default: begin
            pend_in = pend_ff;
         end
      endcase
   end

   // Configuration writes; indexes outside the list are ignored.
   always_comb begin
      light_in = light_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_DIRECTIONAL: light_in.directional = csr_wdata[0];
            CSR_LIGHT_X:     light_in.x = csr_wdata;
            CSR_LIGHT_Y:     light_in.y = csr_wdata;
            CSR_LIGHT_Z:     light_in.z = csr_wdata;
            default:         light_in = light_ff;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         total_ff             <= '0;
         rsp_valid_ff         <= 1'b0;
         light_ff.directional <= 1'b1;
         light_ff.x           <= '0;
         light_ff.y           <= '0;
         light_ff.z           <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         light_ff     <= light_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pend_ff       <= pend_in;
      pend_addr_ff  <= pend_addr_in;
      match_ff      <= match_in;
      edge_sel_ff   <= edge_sel_in;
      vert_a_ff     <= vert_a_in;
      vert_b_ff     <= vert_b_in;
      vert_c_ff     <= vert_c_in;
      slot_ff       <= slot_in;
      facing_ff     <= facing_in;
      ovf_ff        <= ovf_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_facing_ff <= rsp_facing_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_facing      = rsp_facing_ff;
   assign rsp_edge_count  = rsp_count_ff;
   assign rsp_read_first  = rsp_first_ff;
   assign rsp_read_second = rsp_second_ff;
   assign rsp_read_valid  = rsp_rvalid_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   ssef_edge_ram #(
      .DEPTH     (EDGE_CAPACITY),
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (WORD_BITS)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ssef_dot_unit u_dot_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (dot_start),
      .light    (light_ff),
      .normal_x (req_normal_x),
      .normal_y (req_normal_y),
      .normal_z (req_normal_z),
      .center_x (req_center_x),
      .center_y (req_center_y),
      .center_z (req_center_z),
      .done     (dot_done),
      .nonneg   (dot_nonneg)
   );

   // Checks.
   `SSEF_NEVER(a_total_bound, total_ff > CAP_CNT, "edge count above capacity")
   `SSEF_NEVER(a_no_rw_overlap, ram_we && ram_re, "table read and write in one cycle")
   `SSEF_CHECK(a_move_shrinks, state_ff == ST_MOVE |=> total_ff == $past(last_idx), "move did not shrink table")
   `SSEF_NEVER(a_dot_done_state, dot_done && state_ff != ST_DOT, "dot result outside dot state")
   `SSEF_CHECK(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "response not from done state")

endmodule

@@ sim/shadow_silhouette_edge_finder_tb.sv @@
// ----------------------------------------------------------------------------
// shadow_silhouette_edge_finder_tb
// Self-checking testbench for the silhouette edge finder. A short table of
// directed requests runs first, then randomized request streams under several
// light settings, one of them with no idle gaps on either side.
// Every response is checked field by field against predicted or typed values.
// ----------------------------------------------------------------------------
module shadow_silhouette_edge_finder_tb;
   import ssef_pkg::*;

   localparam int EDGE_SLOTS  = 1024;
   localparam int IDLE_LIMIT  = 20000;
   localparam int MAX_REPORTS = 100;

   // The opcode that the block does not define, and a register index that
   // maps to no register.
   localparam logic [1:0]                OP_UNUSED    = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 8'hFF;

   localparam logic [FIX_BITS-1:0] FIX_MIN = 32'h8000_0000;
   localparam logic [FIX_BITS-1:0] FIX_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [VERT_BITS-1:0] vert_a;
      logic [VERT_BITS-1:0] vert_b;
      logic [VERT_BITS-1:0] vert_c;
      logic [FIX_BITS-1:0]  normal_x;
      logic [FIX_BITS-1:0]  normal_y;
      logic [FIX_BITS-1:0]  normal_z;
      logic [FIX_BITS-1:0]  center_x;
      logic [FIX_BITS-1:0]  center_y;
      logic [FIX_BITS-1:0]  center_z;
      logic [SLOT_BITS-1:0] slot;
   } edge_request_type;

   typedef struct packed {
      logic                      facing;
      logic [COUNT_OUT_BITS-1:0] edge_count;
      logic [VERT_BITS-1:0]      read_first;
      logic [VERT_BITS-1:0]      read_second;
      logic                      read_valid;
      logic                      overflow;
   } edge_result_type;

   // A directed row is either a request checked against the predictor, a
   // request whose response is written out by hand, or a register write.
   typedef enum logic [1:0] {
      ROW_CHECKED,
      ROW_TYPED,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      edge_request_type          rq;
      edge_result_type           want;
      logic [CSR_INDEX_BITS-1:0] csr_idx;
      logic [FIX_BITS-1:0]       csr_data;
   } stim_row_type;

   // ---------------------------------------------------------------------
   // Block ports. Every input holds a known value from time zero.
   // ---------------------------------------------------------------------
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_opcode = OP_CLEAR;
   logic [VERT_BITS-1:0]      req_vert_a = '0;
   logic [VERT_BITS-1:0]      req_vert_b = '0;
   logic [VERT_BITS-1:0]      req_vert_c = '0;
   logic signed [FIX_BITS-1:0] req_normal_x = '0;
   logic signed [FIX_BITS-1:0] req_normal_y = '0;
   logic signed [FIX_BITS-1:0] req_normal_z = '0;
   logic signed [FIX_BITS-1:0] req_center_x = '0;
   logic signed [FIX_BITS-1:0] req_center_y = '0;
   logic signed [FIX_BITS-1:0] req_center_z = '0;
   logic [SLOT_BITS-1:0]      req_slot = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_facing;
   logic [COUNT_OUT_BITS-1:0] rsp_edge_count;
   logic [VERT_BITS-1:0]      rsp_read_first;
   logic [VERT_BITS-1:0]      rsp_read_second;
   logic                      rsp_read_valid;
   logic                      rsp_overflow;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [FIX_BITS-1:0]       csr_wdata = '0;

   shadow_silhouette_edge_finder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_vert_a      (req_vert_a),
      .req_vert_b      (req_vert_b),
      .req_vert_c      (req_vert_c),
      .req_normal_x    (req_normal_x),
      .req_normal_y    (req_normal_y),
      .req_normal_z    (req_normal_z),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_center_z    (req_center_z),
      .req_slot        (req_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_facing      (rsp_facing),
      .rsp_edge_count  (rsp_edge_count),
      .rsp_read_first  (rsp_read_first),
      .rsp_read_second (rsp_read_second),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_overflow    (rsp_overflow),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the edge table and of the light.
   // ---------------------------------------------------------------------
   logic [VERT_BITS-1:0] held_first  [EDGE_SLOTS];
   logic [VERT_BITS-1:0] held_second [EDGE_SLOTS];
   int unsigned          held_count = 0;
   ssef_light_type       light_cfg = '{directional: 1'b1, x: '0, y: '0, z: '0};

   // Responses the block still owes, oldest first.
   edge_result_type pending_results[$];

   // Traffic shaping shared between the driver and the response side.
   logic steady = 1'b0;      // no gaps on either side while set
   int   hold_request = 0;   // cycles the receiver is asked to hold off
   int   hold_left = 0;
   int   stall_left = 0;

   // Run statistics.
   int error_count   = 0;
   int requests_sent = 0;
   int results_seen  = 0;
   int facing_seen   = 0;
   int dropped_seen  = 0;
   int peak_edges    = 0;
   int idle_cycles   = 0;

   stim_row_type directed_rows[$];

   // ---------------------------------------------------------------------
   // Edge table predictor.
   // ---------------------------------------------------------------------

   // Toggles one edge in the predicted table. An edge already held in
   // either direction is removed by moving the last entry into its slot;
   // a new edge is appended. Returns 1 when the append is dropped because
   // the table is full.
   function automatic logic toggle_edge(logic [VERT_BITS-1:0] p, logic [VERT_BITS-1:0] q);
      for (int i = 0; i < held_count; i++) begin
         if ((held_first[i] == p && held_second[i] == q) ||
             (held_first[i] == q && held_second[i] == p)) begin
            held_first[i]  = held_first[held_count - 1];
            held_second[i] = held_second[held_count - 1];
            held_count--;
            return 1'b0;
         end
      end
      if (held_count >= EDGE_SLOTS) begin
         return 1'b1;
      end
      held_first[held_count]  = p;
      held_second[held_count] = q;
      held_count++;
      return 1'b0;
   endfunction

   // Works out the response to one request and advances the predicted table.
   // The facing test is the exact sign of a 68-bit dot product: a normal
   // component of 32 bits times a light vector component of up to 33 bits.
   function automatic edge_result_type silhouette_predict(edge_request_type rq);
      edge_result_type            res;
      logic signed [VEC_BITS-1:0] vx;
      logic signed [VEC_BITS-1:0] vy;
      logic signed [VEC_BITS-1:0] vz;
      logic signed [ACC_BITS-1:0] dot;
      res = '0;
      case (rq.opcode)
         OP_CLEAR: begin
            held_count = 0;
         end
         OP_TRIANGLE: begin
            if (light_cfg.directional) begin
               vx = $signed(light_cfg.x);
               vy = $signed(light_cfg.y);
               vz = $signed(light_cfg.z);
            end else begin
               // A point light looks along center minus light position.
               vx = $signed(rq.center_x) - $signed(light_cfg.x);
               vy = $signed(rq.center_y) - $signed(light_cfg.y);
               vz = $signed(rq.center_z) - $signed(light_cfg.z);
            end
            dot = $signed(rq.normal_x) * vx + $signed(rq.normal_y) * vy +
                  $signed(rq.normal_z) * vz;
            // A dot product of exactly zero still counts as facing.
            if (!dot[ACC_BITS-1]) begin
               res.facing = 1'b1;
               if (toggle_edge(rq.vert_a, rq.vert_b)) res.overflow = 1'b1;
               if (toggle_edge(rq.vert_b, rq.vert_c)) res.overflow = 1'b1;
               if (toggle_edge(rq.vert_c, rq.vert_a)) res.overflow = 1'b1;
            end
         end
         OP_READ: begin
            if (rq.slot < held_count) begin
               res.read_valid  = 1'b1;
               res.read_first  = held_first[rq.slot];
               res.read_second = held_second[rq.slot];
            end
         end
         default: begin
            // The unused opcode leaves the table alone and reads nothing.
         end
      endcase
      res.edge_count = COUNT_OUT_BITS'(held_count);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request and row builders.
   // ---------------------------------------------------------------------
   function automatic edge_request_type mk_tri(
         logic [VERT_BITS-1:0] a, logic [VERT_BITS-1:0] b, logic [VERT_BITS-1:0] c,
         logic [FIX_BITS-1:0] nx, logic [FIX_BITS-1:0] ny, logic [FIX_BITS-1:0] nz,
         logic [FIX_BITS-1:0] cx, logic [FIX_BITS-1:0] cy, logic [FIX_BITS-1:0] cz);
      edge_request_type rq;
      rq          = '0;
      rq.opcode   = OP_TRIANGLE;
      rq.vert_a   = a;
      rq.vert_b   = b;
      rq.vert_c   = c;
      rq.normal_x = nx;
      rq.normal_y = ny;
      rq.normal_z = nz;
      rq.center_x = cx;
      rq.center_y = cy;
      rq.center_z = cz;
      return rq;
   endfunction

   function automatic edge_request_type mk_op(logic [1:0] op, logic [SLOT_BITS-1:0] slot);
      edge_request_type rq;
      rq        = '0;
      rq.opcode = op;
      rq.slot   = slot;
      return rq;
   endfunction

   function automatic edge_result_type mk_res(logic facing, logic [COUNT_OUT_BITS-1:0] count,
         logic [VERT_BITS-1:0] first, logic [VERT_BITS-1:0] second,
         logic read_valid, logic overflow);
      edge_result_type res;
      res.facing      = facing;
      res.edge_count  = count;
      res.read_first  = first;
      res.read_second = second;
      res.read_valid  = read_valid;
      res.overflow    = overflow;
      return res;
   endfunction

   function automatic stim_row_type req_row(row_kind_type kind, edge_request_type rq,
         edge_result_type want);
      stim_row_type r;
      r      = '0;
      r.kind = kind;
      r.rq   = rq;
      r.want = want;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_INDEX_BITS-1:0] idx,
         logic [FIX_BITS-1:0] data);
      stim_row_type r;
      r          = '0;
      r.kind     = ROW_CSR;
      r.csr_idx  = idx;
      r.csr_data = data;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Random value sources.
   // ---------------------------------------------------------------------

   // Q16.16 values: the extremes often, small magnitudes often, and the
   // full 32-bit range the rest of the time.
   function automatic logic [FIX_BITS-1:0] rand_fix();
      logic [19:0] small_mag;
      small_mag = 20'($urandom);
      case ($urandom_range(0, 9))
         0: return FIX_MIN;
         1: return FIX_MAX;
         2: return '0;
         3: return '1;
         4, 5: return {{12{small_mag[19]}}, small_mag};
         default: return FIX_BITS'($urandom);
      endcase
   endfunction

   // Vertex indices mostly come from a tiny pool so that triangles share
   // edges and removals happen; some span the full 16 bits.
   function automatic logic [VERT_BITS-1:0] rand_vert();
      if ($urandom_range(0, 9) < 7) begin
         return VERT_BITS'($urandom_range(0, 5));
      end
      return VERT_BITS'($urandom);
   endfunction

   // Idle gap length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   // ---------------------------------------------------------------------
   // Checking.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("tb: mismatch at %0t: %s", $time, what);
      end
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("response %0d %s is %0h, expected %0h",
                                   results_seen, name, got, want));
      end
   endtask

   // Responses are taken at the rising edge and matched in order against
   // the oldest outstanding prediction.
   always @(posedge clock) begin : response_check
      edge_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_facing === 1'b1) facing_seen++;
         if (rsp_overflow === 1'b1) dropped_seen++;
         if (int'(rsp_edge_count) > peak_edges) peak_edges = int'(rsp_edge_count);
         if (pending_results.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            check_field("facing", 32'(rsp_facing), 32'(want.facing));
            check_field("edge_count", 32'(rsp_edge_count), 32'(want.edge_count));
            check_field("read_first", 32'(rsp_read_first), 32'(want.read_first));
            check_field("read_second", 32'(rsp_read_second), 32'(want.read_second));
            check_field("read_valid", 32'(rsp_read_valid), 32'(want.read_valid));
            check_field("overflow", 32'(rsp_overflow), 32'(want.overflow));
         end
      end
   end

   // The response side decides its ready at each falling edge. A hold-off
   // asked for by the stimulus is loaded here and counted down in this
   // process; otherwise ready drops at random for gaps of random length.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (steady || $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         stall_left = pick_gap();
      end
   end

   // Watchdog: the slowest request is a facing triangle scanning a full table,
   // and stalls on either side add to it, so a long stretch with no handshake
   // at all means the block is stuck.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Driving. Inputs change at the falling edge only.
   // ---------------------------------------------------------------------

   // Offers one request after a random gap (none while steady), holds it
   // until the block takes it, and queues the expected response at the
   // accepting edge; for hand-written rows the written value is queued while
   // the predictor still advances its table.
   task automatic send_request(edge_request_type rq, logic typed, edge_result_type typed_res);
      edge_result_type predicted;
      int              gap;
      gap = steady ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_opcode   <= rq.opcode;
      req_vert_a   <= rq.vert_a;
      req_vert_b   <= rq.vert_b;
      req_vert_c   <= rq.vert_c;
      req_normal_x <= rq.normal_x;
      req_normal_y <= rq.normal_y;
      req_normal_z <= rq.normal_z;
      req_center_x <= rq.center_x;
      req_center_y <= rq.center_y;
      req_center_z <= rq.center_z;
      req_slot     <= rq.slot;
      do @(posedge clock); while (!req_ready);
      predicted = silhouette_predict(rq);
      pending_results.push_back(typed ? typed_res : predicted);
      requests_sent++;
   endtask

   // Stops offering requests and waits until every response has come back,
   // so that the block is idle and the light may be changed.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one light register and mirrors it in the predictor. Unmapped
   // indexes change nothing.
   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [FIX_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DIRECTIONAL: light_cfg.directional = data[0];
         CSR_LIGHT_X:     light_cfg.x = data;
         CSR_LIGHT_Y:     light_cfg.y = data;
         CSR_LIGHT_Z:     light_cfg.z = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One randomized phase: a fresh light, then a mix of clears, triangles,
   // reads and the unused opcode. Unused fields carry random noise.
   task automatic random_phase(int n_items);
      edge_request_type rq;
      int unsigned      roll;
      csr_write(CSR_DIRECTIONAL, FIX_BITS'($urandom));
      csr_write(CSR_LIGHT_X, rand_fix());
      csr_write(CSR_LIGHT_Y, rand_fix());
      csr_write(CSR_LIGHT_Z, rand_fix());
      for (int n = 0; n < n_items; n++) begin
         roll        = $urandom_range(0, 99);
         rq.opcode   = roll < 5 ? OP_CLEAR : roll < 65 ? OP_TRIANGLE :
                       roll < 95 ? OP_READ : OP_UNUSED;
         rq.vert_a   = rand_vert();
         rq.vert_b   = rand_vert();
         rq.vert_c   = rand_vert();
         rq.normal_x = rand_fix();
         rq.normal_y = rand_fix();
         rq.normal_z = rand_fix();
         rq.center_x = rand_fix();
         rq.center_y = rand_fix();
         rq.center_z = rand_fix();
         // Reads aim mostly near the current count, sometimes anywhere.
         if ($urandom_range(0, 3) != 0) begin
            rq.slot = SLOT_BITS'($urandom_range(0, held_count + 1));
         end else begin
            rq.slot = SLOT_BITS'($urandom);
         end
         send_request(rq, 1'b0, '0);
      end
      drain_results();
   endtask

   // ---------------------------------------------------------------------
   // Stimulus sequence.
   // ---------------------------------------------------------------------
   initial begin
      // Directed table. After reset the light is directional and zero, so
      // every dot product is exactly zero and every triangle faces; the
      // first rows can therefore be written out by hand.
      directed_rows.push_back(req_row(ROW_TYPED, mk_op(OP_READ, 10'd0),
                                      mk_res(1'b0, 11'd0, 16'd0, 16'd0, 1'b0, 1'b0)));
      directed_rows.push_back(req_row(ROW_TYPED, mk_op(OP_UNUSED, 10'd5),
                                      mk_res(1'b0, 11'd0, 16'd0, 16'd0, 1'b0, 1'b0)));
      directed_rows.push_back(req_row(ROW_TYPED,
         mk_tri(16'd1, 16'd2, 16'd3, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN),
         mk_res(1'b1, 11'd3, 16'd0, 16'd0, 1'b0, 1'b0)));
      directed_rows.push_back(req_row(ROW_TYPED, mk_op(OP_READ, 10'd0),
                                      mk_res(1'b0, 11'd3, 16'd1, 16'd2, 1'b1, 1'b0)));
      directed_rows.push_back(req_row(ROW_TYPED, mk_op(OP_READ, 10'd2),
                                      mk_res(1'b0, 11'd3, 16'd3, 16'd1, 1'b1, 1'b0)));
      directed_rows.push_back(req_row(ROW_TYPED, mk_op(OP_READ, 10'd3),
                                      mk_res(1'b0, 11'd3, 16'd0, 16'd0, 1'b0, 1'b0)));
      directed_rows.push_back(req_row(ROW_TYPED, mk_op(OP_READ, 10'd1023),
                                      mk_res(1'b0, 11'd3, 16'd0, 16'd0, 1'b0, 1'b0)));
      // The same triangle wound the other way finds each of its edges stored
      // in reverse and empties the table.
      directed_rows.push_back(req_row(ROW_TYPED,
         mk_tri(16'd1, 16'd3, 16'd2, '0, '0, '0, '0, '0, '0),
         mk_res(1'b1, 11'd0, 16'd0, 16'd0, 1'b0, 1'b0)));
      // A fully degenerate triangle appends, removes, then appends again.
      directed_rows.push_back(req_row(ROW_TYPED,
         mk_tri(16'hFFFF, 16'hFFFF, 16'hFFFF, FIX_MIN, FIX_MIN, FIX_MIN, '1, '1, '1),
         mk_res(1'b1, 11'd1, 16'd0, 16'd0, 1'b0, 1'b0)));
      directed_rows.push_back(req_row(ROW_TYPED, mk_op(OP_READ, 10'd0),
                                      mk_res(1'b0, 11'd1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0)));
      directed_rows.push_back(req_row(ROW_TYPED, mk_op(OP_CLEAR, 10'h3FF),
                                      mk_res(1'b0, 11'd0, 16'd0, 16'd0, 1'b0, 1'b0)));
      // Directional light at the extremes of y and z.
      directed_rows.push_back(csr_row(CSR_DIRECTIONAL, 32'd1));
      directed_rows.push_back(csr_row(CSR_LIGHT_X, 32'h0001_0000));
      directed_rows.push_back(csr_row(CSR_LIGHT_Y, FIX_MIN));
      directed_rows.push_back(csr_row(CSR_LIGHT_Z, FIX_MAX));
      directed_rows.push_back(req_row(ROW_CHECKED,
         mk_tri(16'd0, 16'hFFFF, 16'h5555, '0, '0, FIX_MAX, '0, '0, '0), '0));
      directed_rows.push_back(req_row(ROW_CHECKED,
         mk_tri(16'hAAAA, 16'h5555, 16'd0, '0, 32'd1, '0, '0, '0, '0), '0));
      directed_rows.push_back(req_row(ROW_CHECKED,
         mk_tri(16'd7, 16'd8, 16'd9, FIX_MIN, FIX_MIN, FIX_MIN, '0, '0, '0), '0));
      // The two products cancel exactly, so this one faces on a zero sum.
      directed_rows.push_back(req_row(ROW_CHECKED,
         mk_tri(16'd0, 16'hFFFF, 16'd1, 32'h0000_8000, 32'd1, '0, '0, '0, '0), '0));
      directed_rows.push_back(req_row(ROW_CHECKED, mk_op(OP_READ, 10'd0), '0));
      // Point light at extreme coordinates, giving 33-bit light vectors.
      directed_rows.push_back(csr_row(CSR_DIRECTIONAL, 32'd0));
      directed_rows.push_back(csr_row(CSR_LIGHT_X, FIX_MIN));
      directed_rows.push_back(csr_row(CSR_LIGHT_Y, FIX_MAX));
      directed_rows.push_back(csr_row(CSR_LIGHT_Z, '0));
      directed_rows.push_back(req_row(ROW_CHECKED,
         mk_tri(16'd2, 16'd4, 16'd6, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, '1), '0));
      directed_rows.push_back(req_row(ROW_CHECKED,
         mk_tri(16'd6, 16'd4, 16'd2, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MIN, FIX_MAX, '0), '0));
      directed_rows.push_back(req_row(ROW_CHECKED, mk_op(OP_READ, 10'd1), '0));

      // Synchronous reset, held from time zero and released once.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_results();
            csr_write(directed_rows[i].csr_idx, directed_rows[i].csr_data);
         end else begin
            send_request(directed_rows[i].rq, directed_rows[i].kind == ROW_TYPED,
                         directed_rows[i].want);
         end
      end
      drain_results();

      // The receiver holds off for a long stretch while requests keep
      // coming, so the block backs up and drops its request ready.
      hold_request = 300;
      random_phase(30);
      random_phase(30);
      // A write to an unmapped index must leave the light untouched.
      csr_write(CSR_UNMAPPED, FIX_BITS'($urandom));
      random_phase(28);
      steady = 1'b1;
      random_phase(30);
      steady = 1'b0;
      random_phase(28);
      random_phase(28);

      // Everything has been answered; give the block a little longer to
      // show any stray response.
      drain_results();
      repeat (20) @(posedge clock);

      $display("tb: %0d requests sent, %0d responses checked, %0d facing triangles",
               requests_sent, results_seen, facing_seen);
      $display("tb: table peaked at %0d edges, %0d responses flagged dropped edges",
               peak_edges, dropped_seen);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
